// File: src/swscan_pkg.sv
// Package for the expression word scanner.
// Holds word kind and status codes, match constants and the queue entry type.
// No dependencies.
`default_nettype none
package swscan_pkg;

  localparam int WORD_W   = 32;
  localparam int KIND_W   = 5;
  localparam int STATUS_W = 2;
  localparam int SEEN_W   = 16;
  localparam int QDEPTH   = 2;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SEEN_W-1:0]   seen_t;

  localparam kind_t KIND_STOP      = 5'd0;
  localparam kind_t KIND_COMPARE   = 5'd1;
  localparam kind_t KIND_OVERWRITE = 5'd2;
  localparam kind_t KIND_ARITH     = 5'd3;
  localparam kind_t KIND_INERT     = 5'd4;
  localparam kind_t KIND_FLOAT_LIT = 5'd5;
  localparam kind_t KIND_DEC_LIT   = 5'd6;
  localparam kind_t KIND_BYTE_VAR  = 5'd7;
  localparam kind_t KIND_BIT_VAR   = 5'd8;
  localparam kind_t KIND_FLOAT_VAR = 5'd9;
  localparam kind_t KIND_SECONDARY = 5'd10;
  localparam kind_t KIND_NEG_LOW16 = 5'd11;
  localparam kind_t KIND_DIRECT    = 5'd12;
  localparam kind_t KIND_NEG_INT   = 5'd13;
  localparam kind_t KIND_INLINE    = 5'd14;
  localparam kind_t KIND_PAYLOAD   = 5'd15;
  localparam kind_t KIND_IGNORED   = 5'd16;

  localparam status_t STATUS_COMPLETE  = 2'd0;
  localparam status_t STATUS_NO_STOP   = 2'd1;
  localparam status_t STATUS_TRUNCATED = 2'd2;

  localparam word_t INLINE_A = 32'h7f7f_ffff;
  localparam word_t INLINE_B = 32'h0080_0000;
  localparam word_t INLINE_C = 32'h7fff_ffff;
  localparam word_t INLINE_D = 32'h7fff_fffe;

  localparam word_t LIM_INERT     = 32'h0400_0000;
  localparam word_t LIM_FLOAT_LIT = 32'h0800_0000;
  localparam word_t LIM_DEC_LIT   = 32'h1000_0000;
  localparam word_t LIM_BYTE_VAR  = 32'h2000_0000;
  localparam word_t LIM_BIT_VAR   = 32'h4000_0000;
  localparam word_t LIM_FLOAT_VAR = 32'h5000_0000;

  localparam logic [23:0] IDX_SECONDARY = 24'h00_004a;
  localparam logic [23:0] IDX_LOW16     = 24'h00_000f;

  typedef struct packed {
    kind_t kind;
    logic  inline_word;
    logic  first;
  } swscan_item_t;

  typedef struct packed {
    logic         valid;
    swscan_item_t item;
  } swscan_q_t;

endpackage
`default_nettype wire

// File: src/script_word_scanner_core.sv
// Top level of the expression word scanner: stop code register, classifier,
// queue and state tracker. Depends on swscan_pkg and the swscan_* modules.
//
//   Channel | Ports                                          | Direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_stall, in_code_word, in_first_word | in
//   result  | out_valid, out_stall, out_word_kind ...         | out
//   config  | cfg_wr_en, cfg_wr_data (stop code)              | in
//
// One word per clock is sustained while out_stall is low; a word passes through
// the two-entry queue and then the result register.
// The state update in the back end sets that rate.
// Reset is synchronous and restores the stop code to all ones and clears state.
// A stalled result register stops the back end; the queue then fills and
// in_stall rises after at most two further beats.
`default_nettype none
module script_word_scanner_core
  import swscan_pkg::*;
#(
  parameter longint unsigned COUNT_MAX = 65535
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire word_t cfg_wr_data,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire word_t in_code_word,
  input  wire logic  in_first_word,
  output logic       out_valid,
  input  wire logic  out_stall,
  output kind_t      out_word_kind,
  output logic       out_keep_going,
  output logic       out_is_complete,
  output logic       out_is_inline,
  output seen_t      out_words_seen,
  output status_t    out_scan_status
);

  word_t        stop_code_r;
  word_t        stop_code_nxt;
  swscan_item_t front_item;
  swscan_q_t    q_head;
  logic         q_full;
  logic         q_pop;

  assign stop_code_nxt = cfg_wr_en ? cfg_wr_data : stop_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_code_r <= '1;
    end else begin
      stop_code_r <= stop_code_nxt;
    end
  end

  assign in_stall = q_full;

  swscan_front u_front (
    .code_word  (in_code_word),
    .first_word (in_first_word),
    .stop_code  (stop_code_r),
    .item       (front_item)
  );

  swscan_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  swscan_back #(
    .COUNT_MAX (COUNT_MAX)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_kind   (out_word_kind),
    .out_keep_going  (out_keep_going),
    .out_is_complete (out_is_complete),
    .out_is_inline   (out_is_inline),
    .out_words_seen  (out_words_seen),
    .out_scan_status (out_scan_status)
  );

endmodule
`default_nettype wire

// File: src/swscan_front.sv
// Front end of the scanner: classifies one word against the stop code and the
// fixed code ranges. Depends on swscan_pkg.
`default_nettype none
module swscan_front
  import swscan_pkg::*;
(
  input  wire word_t        code_word,
  input  wire logic         first_word,
  input  wire word_t        stop_code,
  output swscan_item_t      item
);

  logic [23:0] idx;
  kind_t       int_kind;
  kind_t       kind;

  assign idx = code_word[23:0];

  always_comb begin
    if (idx <= 24'd7 || idx == IDX_SECONDARY) begin
      int_kind = KIND_SECONDARY;
    end else if (idx == IDX_LOW16) begin
      int_kind = KIND_NEG_LOW16;
    end else if (idx >= 24'd24 && idx <= 24'd32) begin
      int_kind = KIND_DIRECT;
    end else begin
      int_kind = KIND_NEG_INT;
    end
  end

  always_comb begin
    if (code_word == stop_code) begin
      kind = KIND_STOP;
    end else if (code_word <= 32'h09 || code_word == 32'h10 || code_word == 32'h11) begin
      kind = KIND_COMPARE;
    end else if (code_word == 32'h0a) begin
      kind = KIND_OVERWRITE;
    end else if ((code_word >= 32'h0b && code_word <= 32'h0f) ||
                 (code_word >= 32'h12 && code_word <= 32'h16)) begin
      kind = KIND_ARITH;
    end else if (code_word < LIM_INERT) begin
      kind = KIND_INERT;
    end else if (code_word < LIM_FLOAT_LIT) begin
      kind = KIND_FLOAT_LIT;
    end else if (code_word < LIM_DEC_LIT) begin
      kind = KIND_DEC_LIT;
    end else if (code_word < LIM_BYTE_VAR) begin
      kind = KIND_BYTE_VAR;
    end else if (code_word < LIM_BIT_VAR) begin
      kind = KIND_BIT_VAR;
    end else if (code_word < LIM_FLOAT_VAR) begin
      kind = KIND_FLOAT_VAR;
    end else begin
      kind = int_kind;
    end
  end

  assign item.kind        = kind;
  assign item.inline_word = (code_word == INLINE_A) || (code_word == INLINE_B) ||
                            (code_word == INLINE_C) || (code_word == INLINE_D);
  assign item.first       = first_word;

endmodule
`default_nettype wire

// File: src/swscan_fifo.sv
// Short queue between the classifier and the state tracker.
// Depends on swscan_pkg.
`default_nettype none
module swscan_fifo
  import swscan_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire swscan_item_t push_item,
  input  wire logic         pop,
  output logic              full,
  output swscan_q_t         head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  swscan_item_t     mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> count_r == CNT_FULL)
    else $error("full queue lost an entry");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push && count_r == CNT_W'(1) |=> !head.valid)
    else $error("queue not empty after last entry left");

endmodule
`default_nettype wire

// File: src/swscan_back.sv
// Back end of the scanner: holds the expression state, applies one classified
// word per beat and registers the result. Depends on swscan_pkg.
`default_nettype none
module swscan_back
  import swscan_pkg::*;
#(
  parameter longint unsigned COUNT_MAX = 65535
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire swscan_q_t head,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output kind_t          out_word_kind,
  output logic           out_keep_going,
  output logic           out_is_complete,
  output logic           out_is_inline,
  output seen_t          out_words_seen,
  output status_t        out_scan_status
);

  localparam int CNT_W = $clog2(64'(COUNT_MAX) + 64'd1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  logic             done_r;
  logic             done_nxt;
  logic             inline_r;
  logic             inline_nxt;
  logic             pend_r;
  logic             pend_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic             out_valid_r;
  logic             out_valid_nxt;
  kind_t            kind_r;
  kind_t            kind_nxt;
  logic             more_r;
  logic             more_nxt;
  logic             complete_r;
  logic             is_inline_r;
  seen_t            seen_r;
  seen_t            seen_nxt;
  status_t          status_r;
  status_t          status_nxt;

  logic             eff_done;
  logic             eff_inline;
  logic             eff_pend;
  logic [CNT_W-1:0] eff_cnt;
  logic [63:0]      cnt_ext;

  assign pop = head.valid && (!out_valid_r || !out_stall);

  always_comb begin
    eff_done   = head.item.first ? 1'b0 : done_r;
    eff_inline = head.item.first ? 1'b0 : inline_r;
    eff_pend   = head.item.first ? 1'b0 : pend_r;
    eff_cnt    = head.item.first ? '0   : cnt_r;

    done_nxt   = eff_done;
    inline_nxt = eff_inline;
    pend_nxt   = eff_pend;
    cnt_nxt    = eff_cnt;
    kind_nxt   = KIND_IGNORED;
    more_nxt   = 1'b0;

    if (!eff_done) begin
      cnt_nxt = (eff_cnt < CNT_LIMIT) ? eff_cnt + CNT_ONE : eff_cnt;
      if (eff_pend) begin
        pend_nxt = 1'b0;
        kind_nxt = KIND_PAYLOAD;
        more_nxt = 1'b1;
      end else if (cnt_nxt == CNT_ONE && head.item.inline_word) begin
        done_nxt   = 1'b1;
        inline_nxt = 1'b1;
        kind_nxt   = KIND_INLINE;
      end else begin
        kind_nxt = head.item.kind;
        if (head.item.kind == KIND_STOP) begin
          done_nxt = 1'b1;
        end else begin
          pend_nxt = (head.item.kind == KIND_FLOAT_LIT);
          more_nxt = 1'b1;
        end
      end
    end

    if (done_nxt) begin
      status_nxt = STATUS_COMPLETE;
    end else if (pend_nxt) begin
      status_nxt = STATUS_TRUNCATED;
    end else begin
      status_nxt = STATUS_NO_STOP;
    end

    cnt_ext  = 64'(cnt_nxt);
    seen_nxt = (cnt_ext > 64'h0000_0000_0000_ffff) ? '1 : cnt_ext[SEEN_W-1:0];

    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      inline_r    <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        done_r   <= done_nxt;
        inline_r <= inline_nxt;
        pend_r   <= pend_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r      <= kind_nxt;
      more_r      <= more_nxt;
      complete_r  <= done_nxt;
      is_inline_r <= inline_nxt;
      seen_r      <= seen_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_kind   = kind_r;
  assign out_keep_going  = more_r;
  assign out_is_complete = complete_r;
  assign out_is_inline   = is_inline_r;
  assign out_words_seen  = seen_r;
  assign out_scan_status = status_r;

  a_ignored_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_IGNORED |-> !more_r && complete_r)
    else $error("ignored word reported while expression still open");

  a_complete_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && complete_r |-> status_r == STATUS_COMPLETE && !more_r)
    else $error("completed expression reported with open status");

  a_payload_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && kind_nxt == KIND_FLOAT_LIT |=> pend_r)
    else $error("float literal did not arm the payload flag");

  a_inline_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_INLINE |-> seen_r == SEEN_W'(1) && is_inline_r)
    else $error("inline value accepted past the first word");

endmodule
`default_nettype wire

// File: test/script_word_scanner_core_test.sv
// Self-checking testbench for script_word_scanner_core: a directed table, then
// random expressions under several stop codes, checked beat by beat against a
// built-in scanner model. Depends on swscan_pkg and the scanner RTL.
`default_nettype none
module script_word_scanner_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swscan_pkg::*;

  localparam int unsigned COUNT_MAX      = 65535;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 4;
  localparam int          HOLD_CYCLES    = 60;
  localparam int          PHASE_WORDS    = 250;
  localparam int          MAX_REPORTS    = 10;

  typedef struct packed {
    kind_t   kind;
    logic    keep_going;
    logic    complete;
    logic    is_inline;
    seen_t   seen;
    status_t status;
  } scan_result_t;

  typedef struct packed {
    logic         has_exp;
    scan_result_t exp;
  } typed_exp_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t      op;
    word_t        word;
    logic         first;
    logic         has_exp;
    scan_result_t exp;
  } dir_row_t;

  localparam scan_result_t NO_RESULT = '0;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_wr_en = 1'b0;
  word_t   cfg_wr_data = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  word_t   in_code_word = '0;
  logic    in_first_word = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  kind_t   out_word_kind;
  logic    out_keep_going;
  logic    out_is_complete;
  logic    out_is_inline;
  seen_t   out_words_seen;
  status_t out_scan_status;

  script_word_scanner_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_word   (in_code_word),
    .in_first_word  (in_first_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_kind  (out_word_kind),
    .out_keep_going (out_keep_going),
    .out_is_complete(out_is_complete),
    .out_is_inline  (out_is_inline),
    .out_words_seen (out_words_seen),
    .out_scan_status(out_scan_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scanner model state and bookkeeping.
  word_t        scan_stop_code = 32'hFFFF_FFFF;
  logic         scan_done = 1'b0;
  logic         scan_inline = 1'b0;
  logic         scan_payload_due = 1'b0;
  int unsigned  scan_count = 0;

  scan_result_t expected_q [$];
  typed_exp_t   typed_q [$];
  int           mismatch_count = 0;
  int           results_checked = 0;
  int           scanned_words = 0;
  int           expressions = 0;
  int           stop_settings = 0;
  int           peak_seen = 0;
  logic [16:0]  kinds_hit = '0;
  int           quiet_cycles = 0;

  int           in_idle_pct = 20;
  int           out_idle_pct = 20;
  logic         hold_request = 1'b0;
  logic         hold_taken = 1'b0;
  int           stall_left = 0;

  dir_row_t dir_rows [25] = '{
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{KIND_STOP, 1'b0, 1'b1, 1'b0, 16'd1, STATUS_COMPLETE}},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b1,
      '{KIND_IGNORED, 1'b0, 1'b1, 1'b0, 16'd1, STATUS_COMPLETE}},
    '{ROW_WORD, INLINE_A, 1'b1, 1'b1,
      '{KIND_INLINE, 1'b0, 1'b1, 1'b1, 16'd1, STATUS_COMPLETE}},
    '{ROW_WORD, 32'h0000_0000, 1'b1, 1'b1,
      '{KIND_COMPARE, 1'b1, 1'b0, 1'b0, 16'd1, STATUS_NO_STOP}},
    '{ROW_WORD, 32'h0000_000A, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h0000_0011, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h0000_0016, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h03FF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h0400_0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, INLINE_B,      1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h0FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h1FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h3FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h4FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h5000_004A, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'hFF00_000F, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'hAB00_0020, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h50FF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h07FF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CFG,  INLINE_C,      1'b0, 1'b0, NO_RESULT},
    '{ROW_WORD, INLINE_C,      1'b1, 1'b0, NO_RESULT},
    '{ROW_WORD, INLINE_D,      1'b1, 1'b0, NO_RESULT},
    '{ROW_WORD, 32'h0000_0005, 1'b1, 1'b0, NO_RESULT},
    '{ROW_WORD, INLINE_C,      1'b0, 1'b0, NO_RESULT}
  };

  function automatic logic is_inline_value(word_t w);
    return w == INLINE_A || w == INLINE_B || w == INLINE_C || w == INLINE_D;
  endfunction

  function automatic kind_t word_class(word_t w);
    logic [23:0] idx;
    idx = w[23:0];
    if (w == scan_stop_code) return KIND_STOP;
    if (w <= 32'h09 || w == 32'h10 || w == 32'h11) return KIND_COMPARE;
    if (w == 32'h0A) return KIND_OVERWRITE;
    if ((w >= 32'h0B && w <= 32'h0F) || (w >= 32'h12 && w <= 32'h16)) return KIND_ARITH;
    if (w < LIM_INERT) return KIND_INERT;
    if (w < LIM_FLOAT_LIT) return KIND_FLOAT_LIT;
    if (w < LIM_DEC_LIT) return KIND_DEC_LIT;
    if (w < LIM_BYTE_VAR) return KIND_BYTE_VAR;
    if (w < LIM_BIT_VAR) return KIND_BIT_VAR;
    if (w < LIM_FLOAT_VAR) return KIND_FLOAT_VAR;
    if (idx <= 24'd7 || idx == IDX_SECONDARY) return KIND_SECONDARY;
    if (idx == IDX_LOW16) return KIND_NEG_LOW16;
    if (idx >= 24'd24 && idx <= 24'd32) return KIND_DIRECT;
    return KIND_NEG_INT;
  endfunction

  function automatic scan_result_t scan_word(word_t w, logic first);
    scan_result_t r;
    kind_t        k;
    logic         more;
    if (first) begin
      scan_done = 1'b0;
      scan_inline = 1'b0;
      scan_payload_due = 1'b0;
      scan_count = 0;
    end
    if (scan_done) begin
      k = KIND_IGNORED;
      more = 1'b0;
    end else begin
      if (scan_count < COUNT_MAX) scan_count++;
      if (scan_payload_due) begin
        scan_payload_due = 1'b0;
        k = KIND_PAYLOAD;
        more = 1'b1;
      end else if (scan_count == 1 && is_inline_value(w)) begin
        scan_done = 1'b1;
        scan_inline = 1'b1;
        k = KIND_INLINE;
        more = 1'b0;
      end else begin
        k = word_class(w);
        if (k == KIND_STOP) begin
          scan_done = 1'b1;
          more = 1'b0;
        end else begin
          scan_payload_due = (k == KIND_FLOAT_LIT);
          more = 1'b1;
        end
      end
    end
    r.kind = k;
    r.keep_going = more;
    r.complete = scan_done;
    r.is_inline = scan_inline;
    r.seen = (scan_count > 32'hFFFF) ? 16'hFFFF : scan_count[15:0];
    if (scan_done) r.status = STATUS_COMPLETE;
    else if (scan_payload_due) r.status = STATUS_TRUNCATED;
    else r.status = STATUS_NO_STOP;
    return r;
  endfunction

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    typed_exp_t   typed;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_word_kind, out_keep_going, out_is_complete, out_is_inline,
              out_words_seen, out_scan_status};
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: kind %0d seen %0d", got.kind, got.seen);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (got.kind <= KIND_IGNORED) kinds_hit[got.kind] = 1'b1;
        if (got.seen > peak_seen) peak_seen = got.seen;
        if (got.kind !== want.kind || got.keep_going !== want.keep_going ||
            got.complete !== want.complete || got.is_inline !== want.is_inline ||
            got.seen !== want.seen || got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d", results_checked);
            $display("  expected kind %0d more %b done %b inl %b seen %0d st %0d",
                     want.kind, want.keep_going, want.complete, want.is_inline,
                     want.seen, want.status);
            $display("  got      kind %0d more %b done %b inl %b seen %0d st %0d",
                     got.kind, got.keep_going, got.complete, got.is_inline,
                     got.seen, got.status);
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      typed = typed_q.pop_front();
      want = scan_word(in_code_word, in_first_word);
      if (typed.has_exp) want = typed.exp;
      expected_q = {expected_q, want};
      if (want.kind != KIND_IGNORED) scanned_words++;
      if (in_first_word) expressions++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("script_word_scanner_core_test: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic put_word(word_t w, logic first, logic has_exp = 1'b0,
                          scan_result_t exp = NO_RESULT);
    typed_exp_t te;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    te = '{has_exp, exp};
    typed_q = {typed_q, te};
    @(negedge clk);
    in_valid <= 1'b1;
    in_code_word <= w;
    in_first_word <= first;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_stop_code(word_t v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    scan_stop_code = v;
    stop_settings++;
  endtask

  function automatic word_t pick_inline();
    case ($urandom_range(0, 3))
      0: return INLINE_A;
      1: return INLINE_B;
      2: return INLINE_C;
      default: return INLINE_D;
    endcase
  endfunction

  function automatic word_t pick_word();
    logic [23:0] idx;
    case ($urandom_range(0, 11))
      0: return word_t'($urandom_range(0, 23));
      1: return scan_stop_code;
      2: return pick_inline();
      3: begin
        case ($urandom_range(0, 5))
          0: return LIM_INERT - $urandom_range(0, 1);
          1: return LIM_FLOAT_LIT - $urandom_range(0, 1);
          2: return LIM_DEC_LIT - $urandom_range(0, 1);
          3: return LIM_BYTE_VAR - $urandom_range(0, 1);
          4: return LIM_BIT_VAR - $urandom_range(0, 1);
          default: return LIM_FLOAT_VAR - $urandom_range(0, 1);
        endcase
      end
      4: return $urandom_range(32'h17, 32'h03FF_FFFF);
      5: return LIM_INERT + $urandom_range(0, 32'h03FF_FFFF);
      6: return $urandom_range(32'h0800_0000, 32'h4FFF_FFFF);
      7, 8: begin
        case ($urandom_range(0, 5))
          0: idx = 24'($urandom_range(0, 7));
          1: idx = IDX_SECONDARY;
          2: idx = IDX_LOW16;
          3: idx = 24'($urandom_range(24, 32));
          4: idx = ($urandom_range(0, 1) != 0) ? 24'd33 : 24'd23;
          default: idx = 24'($urandom());
        endcase
        return {8'($urandom_range(8'h50, 8'hFF)), idx};
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_expr();
    int    len;
    int    mode;
    word_t w;
    mode = $urandom_range(0, 9);
    len = $urandom_range(0, 10);
    if (mode == 0) begin
      put_word(pick_inline(), 1'b1);
      if ($urandom_range(0, 2) == 0) put_word(pick_word(), 1'b0);
    end else if (mode == 1) begin
      repeat ($urandom_range(1, 4)) put_word($urandom(), 1'($urandom_range(0, 1)));
    end else begin
      put_word(pick_word(), 1'b1);
      repeat (len) begin
        w = pick_word();
        if (w == scan_stop_code) w = ~w;
        put_word(w, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) put_word(scan_stop_code, 1'b0);
      if ($urandom_range(0, 4) == 0) put_word(pick_word(), 1'b0);
    end
  endtask

  initial begin
    word_t phase_codes [6];
    int    target;
    phase_codes = '{32'h0000_0000, word_t'($urandom()), 32'h0000_000A, LIM_INERT,
                    INLINE_B, 32'hFFFF_FFFF};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        wait_drained();
        set_stop_code(dir_rows[i].word);
      end else begin
        put_word(dir_rows[i].word, dir_rows[i].first, dir_rows[i].has_exp, dir_rows[i].exp);
      end
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      set_stop_code(phase_codes[p]);
      in_idle_pct = (p == 1) ? 0 : $urandom_range(10, 50);
      out_idle_pct = (p == 1) ? 0 : $urandom_range(10, 50);
      if (p == 2) hold_request = 1'b1;
      target = scanned_words + PHASE_WORDS;
      while (scanned_words < target) send_expr();
    end

    // Closing stretch with no idling on either side.
    wait_drained();
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_stop_code(32'hFFFF_FFFF);
    target = scanned_words + 100;
    while (scanned_words < target) send_expr();
    wait_drained();

    $display("checked %0d results over %0d expressions and %0d stop code settings",
             results_checked, expressions, stop_settings);
    $display("%0d of 17 word kinds seen, peak word count %0d, %0d mismatches",
             $countones(kinds_hit), peak_seen, mismatch_count);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("script_word_scanner_core_test: PASS");
    end else begin
      $display("script_word_scanner_core_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
